// ===== design/rrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared widths, table entry layout, controller/datapath command and status
// bundles, and the digit-step remainder function.
// ----------------------------------------------------------------------------
package rrf_pkg;

    // field and storage widths
    localparam int MAX_DIVISOR = 1023;
    localparam int DIV_W       = 10;
    localparam int DIVIDEND_W  = 14;
    localparam int POS_W       = 11;
    localparam int PRE_W       = 10;
    localparam int CNT_W       = 11;
    localparam int TABLE_DEPTH = MAX_DIVISOR + 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int RADIX       = 10;

    // remainder that precedes the first digit
    localparam logic [ADDR_W-1:0] FIRST_REM = ADDR_W'(1);

    // one table entry: divisor tag and digit position of the remainder
    typedef struct packed {
        logic [DIV_W-1:0] tag;
        logic [POS_W-1:0] pos;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic clr_we;     // clearing pass write
        logic load;       // take a new divisor word
        logic init_we;    // record the leading remainder
        logic div_step;   // form the next remainder
        logic check;      // look at the table answer, record or finish
        logic out_load;   // move the result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic in_is_zero;
        logic in_is_one;
        logic hit;
        logic rem_zero;
    } dp_status_t;

    // remainder of dividend / divisor where the quotient is at most ten
    // (ten only on the first step of divisor one)
    function automatic logic [DIV_W-1:0] digit_rem(
        input logic [DIVIDEND_W-1:0] dividend,
        input logic [DIV_W-1:0]      divisor
    );
        logic [DIVIDEND_W-1:0] rem;
        logic [DIVIDEND_W-1:0] mult;
        rem = dividend;
        for (int k = 1; k <= RADIX; k++) begin
            mult = DIVIDEND_W'(divisor) * DIVIDEND_W'(k);
            if (mult <= dividend) begin
                rem = dividend - mult;
            end
        end
        return rem[DIV_W-1:0];
    endfunction

endpackage

// ===== design/reciprocal_repetend_finder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reciprocal_repetend_finder_unit
// Runs the long division of 1/d and reports whether the decimal expansion
// terminates or recurs, with preperiod, period and digit count.
// ----------------------------------------------------------------------------
// usage
//   input channel s_valid/s_ready carries one divisor word (s_divisor).
//   result channel m_valid/m_ready carries one result word per divisor:
//   m_recurring, m_preperiod_len, m_period_len, m_digit_count.
//   one divisor is worked at a time; s_ready is high only while idle.
// digit loop
//   each digit passes through ST_DIV, which forms the remainder and reads the
//   seen-remainder table, then ST_CHECK, which checks the table answer and records it.
//   ST_INIT records the leading remainder before the loop; divisor one skips it,
//   and the digit count is at most d.
//   the table takes one write and one read per cycle, and its read is registered.
//   divisor zero goes straight to ST_FINISH and gives an all-zero result.
// reset
//   after reset a clearing pass writes all 1024 table entries, one per
//   cycle; no divisor is accepted until the pass is done.
// stalls
//   the result sits in an output register; a new divisor is taken while it
//   waits, and the next result is held internally until m_ready frees it.
// ----------------------------------------------------------------------------
module reciprocal_repetend_finder_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rrf_pkg::DIV_W-1:0]  s_divisor,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_recurring,
    output logic [rrf_pkg::PRE_W-1:0]  m_preperiod_len,
    output logic [rrf_pkg::PRE_W-1:0]  m_period_len,
    output logic [rrf_pkg::CNT_W-1:0]  m_digit_count
);
    import rrf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    rrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // division, table and result registers
    rrf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_divisor       (s_divisor),
        .m_recurring     (m_recurring),
        .m_preperiod_len (m_preperiod_len),
        .m_period_len    (m_period_len),
        .m_digit_count   (m_digit_count)
    );

endmodule

// ===== design/rrf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_datapath
// Divisor, dividend, remainder and step registers, the digit-step remainder
// logic, the seen-remainder table and the result and output registers.
// ----------------------------------------------------------------------------
module rrf_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rrf_pkg::dp_cmd_t               cmd,
    output rrf_pkg::dp_status_t            status,
    input  logic [rrf_pkg::DIV_W-1:0]      s_divisor,
    output logic                           m_recurring,
    output logic [rrf_pkg::PRE_W-1:0]      m_preperiod_len,
    output logic [rrf_pkg::PRE_W-1:0]      m_period_len,
    output logic [rrf_pkg::CNT_W-1:0]      m_digit_count
);
    import rrf_pkg::*;

    logic [DIV_W-1:0]      divisor_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [POS_W-1:0]      step_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     clr_addr_next;
    entry_t                rd_data_reg;

    logic                  rec_reg;
    logic [PRE_W-1:0]      pre_reg;
    logic [PRE_W-1:0]      per_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic                  out_rec_reg;
    logic [PRE_W-1:0]      out_pre_reg;
    logic [PRE_W-1:0]      out_per_reg;
    logic [CNT_W-1:0]      out_cnt_reg;

    entry_t                mem [TABLE_DEPTH];

    logic [DIV_W-1:0]      rem_comb;
    logic                  hit;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    entry_t                wr_data;
    logic [POS_W-1:0]      period_full;
    logic [DIVIDEND_W-1:0] rem_times_ten;

    // next remainder from the current dividend
    assign rem_comb = digit_rem(dividend_reg, divisor_reg);

    // entry counts only if tagged with this divisor and written earlier this run
    assign hit = (rd_data_reg.tag == divisor_reg) && (rd_data_reg.pos < step_reg);

    assign period_full   = step_reg - rd_data_reg.pos;
    assign rem_times_ten = (DIVIDEND_W'(rem_reg) << 3) + (DIVIDEND_W'(rem_reg) << 1);

    // status back to the controller
    assign status.clr_done   = (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign status.in_is_zero = (s_divisor == '0);
    assign status.in_is_one  = (s_divisor == DIV_W'(1));
    assign status.hit        = hit;
    assign status.rem_zero   = (rem_reg == '0);

    // table write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (cmd.clr_we) begin
            wr_en = 1'b1;
        end else if (cmd.init_we) begin
            wr_en       = 1'b1;
            wr_addr     = FIRST_REM;
            wr_data.tag = divisor_reg;
        end else if (cmd.check && !hit) begin
            wr_en       = 1'b1;
            wr_addr     = rem_reg;
            wr_data.tag = divisor_reg;
            wr_data.pos = step_reg;
        end
    end

    // seen-remainder table, read address is the remainder being formed
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rem_comb];
    end

    // clearing pass address
    assign clr_addr_next = clr_addr_reg + ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    // long division registers and running result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            divisor_reg  <= s_divisor;
            dividend_reg <= DIVIDEND_W'(RADIX);
            step_reg     <= '0;
            rec_reg      <= 1'b0;
            pre_reg      <= '0;
            per_reg      <= '0;
            cnt_reg      <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_comb;
            step_reg <= step_reg + POS_W'(1);
        end
        if (cmd.check) begin
            if (hit) begin
                rec_reg <= 1'b1;
                pre_reg <= rd_data_reg.pos[PRE_W-1:0];
                per_reg <= period_full[PRE_W-1:0];
                cnt_reg <= CNT_W'(step_reg);
            end else begin
                dividend_reg <= rem_times_ten;
                if (rem_reg == '0) begin
                    cnt_reg <= CNT_W'(step_reg);
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_rec_reg <= rec_reg;
            out_pre_reg <= pre_reg;
            out_per_reg <= per_reg;
            out_cnt_reg <= cnt_reg;
        end
    end

    assign m_recurring     = out_rec_reg;
    assign m_preperiod_len = out_pre_reg;
    assign m_period_len    = out_per_reg;
    assign m_digit_count   = out_cnt_reg;

endmodule

// ===== design/rrf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_ctrl
// Sequencer: table clearing after reset, per-divisor setup, the ST_DIV/ST_CHECK
// digit loop and the output handshake.
// ----------------------------------------------------------------------------
module rrf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rrf_pkg::dp_cmd_t     cmd,
    input  rrf_pkg::dp_status_t  status
);
    import rrf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.in_is_zero) begin
                        state_next = ST_FINISH;
                    end else if (status.in_is_one) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd.init_we = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (status.hit || status.rem_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
